/* rtl/wsa_pkg.sv */
`default_nettype none

package wsa_pkg;

    // Datapath width of both vectoring passes and of the angle accumulator
    localparam int DW = 64;

    // Angle constants in Q60
    localparam logic signed [DW-1:0] PI_Q60  = 64'sh3243F6A8885A308D;
    localparam logic signed [DW-1:0] PI2     = 64'sh1921FB54442D1847;
    localparam logic signed [DW-1:0] M2PI    = 64'sh6487ED5110B4611B;
    localparam logic signed [DW-1:0] QPI_Q60 = 64'sh0C90FDAA22168C23;

    // 4 times the rotation gain 1.64676 in Q16
    localparam logic [18:0] GAIN4 = 19'd431688;

    // Normalized larger part: [2^56, 2^57), unless 0 or already >= 2^57
    localparam int NORM_POS = 56;

    localparam logic [16:0] ASPECT_MAX = 17'd51471;

    typedef struct packed {
        logic nul;
        logic gxz;
        logic gyz;
        logic gxn;
        logic off;
    } flag_t;

    typedef struct packed {
        flag_t      f;
        logic [5:0] s1;
    } pre_t;

    typedef struct packed {
        logic        nul;
        logic        a_pos;
        logic [15:0] aq;
    } post_t;

    // atan(2^-i) in Q60 as a truncated series, evaluated at elaboration
    function automatic logic signed [DW-1:0] atan_pow2(input int i);
        logic signed [DW-1:0] sum;
        logic [DW-1:0]        term;
        int                   sh;
        sum = '0;
        if (i == 0) begin
            return QPI_Q60;
        end
        for (int k = 0; k < 64; k++) begin
            sh = 60 - i * (2 * k + 1);
            if (sh >= 0) begin
                term = (64'd1 << sh) / 64'(2 * k + 1);
                if (k % 2 == 1) begin
                    sum = sum - $signed(term);
                end
                else begin
                    sum = sum + $signed(term);
                end
            end
        end
        return sum;
    endfunction

endpackage

`default_nettype wire

/* rtl/wsa_norm.sv */
`default_nettype none

// Three-stage normalizer: find the larger magnitude, count its shift, shift both.
module wsa_norm #(
    parameter int SIDE_W = 5
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic signed [wsa_pkg::DW-1:0] in_x,
    input  wire logic signed [wsa_pkg::DW-1:0] in_y,
    input  wire logic        [SIDE_W-1:0]      in_side,
    output logic                               out_valid,
    output logic signed      [wsa_pkg::DW-1:0] out_x,
    output logic signed      [wsa_pkg::DW-1:0] out_y,
    output logic             [5:0]             out_s,
    output logic             [SIDE_W-1:0]      out_side
);

    logic                          va_reg, vb_reg, vc_reg;
    logic signed [wsa_pkg::DW-1:0] xa_reg, ya_reg, xb_reg, yb_reg, xc_reg, yc_reg;
    logic        [wsa_pkg::DW-1:0] ma_reg, ma_next;
    logic        [SIDE_W-1:0]      sa_reg, sb_reg, sc_reg;
    logic        [5:0]             shb_reg, shb_next, shc_reg;

    always_comb
    begin
        logic [wsa_pkg::DW-1:0] mx, my;
        mx = in_x[wsa_pkg::DW-1] ? 64'(-in_x) : 64'(in_x);
        my = in_y[wsa_pkg::DW-1] ? 64'(-in_y) : 64'(in_y);
        ma_next = (my > mx) ? my : mx;
    end

    // shift lifting the leading one to bit 56; none if at or above it, or if zero
    always_comb
    begin
        logic [5:0] pos;
        pos = '0;
        for (int i = 0; i < wsa_pkg::DW; i++) begin
            if (ma_reg[i]) begin
                pos = 6'(i);
            end
        end
        if (ma_reg == '0 || pos >= 6'(wsa_pkg::NORM_POS)) begin
            shb_next = '0;
        end
        else begin
            shb_next = 6'(wsa_pkg::NORM_POS) - pos;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (en) begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            xa_reg  <= in_x;
            ya_reg  <= in_y;
            ma_reg  <= ma_next;
            sa_reg  <= in_side;
            xb_reg  <= xa_reg;
            yb_reg  <= ya_reg;
            shb_reg <= shb_next;
            sb_reg  <= sa_reg;
            xc_reg  <= xb_reg <<< shb_reg;
            yc_reg  <= yb_reg <<< shb_reg;
            shc_reg <= shb_reg;
            sc_reg  <= sb_reg;
        end
    end

    assign out_valid = vc_reg;
    assign out_x     = xc_reg;
    assign out_y     = yc_reg;
    assign out_s     = shc_reg;
    assign out_side  = sc_reg;

endmodule

`default_nettype wire

/* rtl/wsa_cordic.sv */
`default_nettype none

// Vectoring rotator, one micro-rotation per register stage.
module wsa_cordic #(
    parameter int STAGES = 16,
    parameter int SIDE_W = 11
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic signed [wsa_pkg::DW-1:0] in_x,
    input  wire logic signed [wsa_pkg::DW-1:0] in_y,
    input  wire logic        [SIDE_W-1:0]      in_side,
    output logic                               out_valid,
    output logic signed      [wsa_pkg::DW-1:0] out_x,
    output logic signed      [wsa_pkg::DW-1:0] out_z,
    output logic             [SIDE_W-1:0]      out_side
);

    logic                          v_reg [STAGES];
    logic signed [wsa_pkg::DW-1:0] x_reg [STAGES];
    logic signed [wsa_pkg::DW-1:0] y_reg [STAGES];
    logic signed [wsa_pkg::DW-1:0] z_reg [STAGES];
    logic        [SIDE_W-1:0]      s_reg [STAGES];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam logic signed [wsa_pkg::DW-1:0] ATAN_I = wsa_pkg::atan_pow2(i);

        logic                          cv;
        logic signed [wsa_pkg::DW-1:0] cx, cy, cz, x_next, y_next, z_next;
        logic        [SIDE_W-1:0]      cs;

        if (i == 0) begin : g_first
            assign cv = in_valid;
            assign cx = in_x;
            assign cy = in_y;
            assign cz = '0;
            assign cs = in_side;
        end
        else begin : g_rest
            assign cv = v_reg[i-1];
            assign cx = x_reg[i-1];
            assign cy = y_reg[i-1];
            assign cz = z_reg[i-1];
            assign cs = s_reg[i-1];
        end

        // rotate toward the x axis
        always_comb
        begin
            if (cy > 0) begin
                x_next = cx + (cy >>> i);
                y_next = cy - (cx >>> i);
                z_next = cz + ATAN_I;
            end
            else begin
                x_next = cx - (cy >>> i);
                y_next = cy + (cx >>> i);
                z_next = cz - ATAN_I;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                v_reg[i] <= 1'b0;
            end
            else if (en) begin
                v_reg[i] <= cv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en) begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
                s_reg[i] <= cs;
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_x     = x_reg[STAGES-1];
    assign out_z     = z_reg[STAGES-1];
    assign out_side  = s_reg[STAGES-1];

endmodule

`default_nettype wire

/* rtl/window_slope_aspect_unit.sv */
`default_nettype none

// Channel   | Handshake            | Payload
// ----------+----------------------+-------------------------------------------
// window in | in_valid / in_stall  | elev_nw..elev_se, null_mask, at_border
// result    | out_valid/ out_stall | slope_angle, aspect_angle, is_null
// config    | APB write, pready=1  | ew_cell_size @0x0, ns_cell_size @0x4
//
// One window per clock while in_stall is low. The pipeline is three gradient
// stages, two normalizers of three stages, two vectoring rotators of
// CORDIC_STAGES stages each, three angle stages and the result register.
// Reset clears valid bits and sets both cell sizes to 16.
// A stalled result moves into a skid register, so one more window is taken
// behind it; the whole pipeline then holds until the skid register drains.
// Cell size changes reach the gain product through hv_reg and then b_reg.
module window_slope_aspect_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // window request
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [23:0] elev_nw,
    input  wire logic signed [23:0] elev_n,
    input  wire logic signed [23:0] elev_ne,
    input  wire logic signed [23:0] elev_w,
    input  wire logic signed [23:0] elev_c,
    input  wire logic signed [23:0] elev_e,
    input  wire logic signed [23:0] elev_sw,
    input  wire logic signed [23:0] elev_s,
    input  wire logic signed [23:0] elev_se,
    input  wire logic        [8:0]  null_mask,
    input  wire logic               at_border,
    // result request
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic             [14:0] slope_angle,
    output logic             [15:0] aspect_angle,
    output logic                    is_null,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic        [2:0]  paddr,
    input  wire logic        [31:0] pwdata,
    output logic             [31:0] prdata,
    output logic                    pready
);

    localparam int DW = wsa_pkg::DW;

    // ---------------- configuration ----------------
    logic [19:0] ew_reg, ns_reg;
    logic [19:0] h_eff, v_eff;
    logic [39:0] hv_reg;
    logic [58:0] b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            ew_reg <= 20'd16;
            ns_reg <= 20'd16;
        end
        else if (psel && penable && pwrite) begin
            if (paddr[2]) begin
                ns_reg <= pwdata[19:0];
            end
            else begin
                ew_reg <= pwdata[19:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = paddr[2] ? {12'd0, ns_reg} : {12'd0, ew_reg};

    // a zero spacing counts as one
    assign h_eff = (ew_reg == '0) ? 20'd1 : ew_reg;
    assign v_eff = (ns_reg == '0) ? 20'd1 : ns_reg;

    // reference magnitude 4 * gain * h * v, held steady between writes
    always_ff @(posedge clk)
    begin
        hv_reg <= 40'(h_eff) * 40'(v_eff);
        b_reg  <= 59'(hv_reg) * 59'(wsa_pkg::GAIN4);
    end

    // ---------------- flow control ----------------
    logic adv;
    logic sk_v_reg, p_v_reg;
    logic [14:0] sk_slope_reg, p_slope_reg;
    logic [15:0] sk_asp_reg, p_asp_reg;
    logic        sk_nul_reg, p_nul_reg;

    // advance everything while the skid register is empty
    assign adv      = !sk_v_reg;
    assign in_stall = !adv;

    // ---------------- stage 1: Sobel gradients ----------------
    logic               v1_reg;
    logic signed [26:0] gx1_reg, gy1_reg, gx1_next, gy1_next;
    logic               nul1_reg;

    always_comb
    begin
        logic signed [26:0] lft, rgt, bot, top;
        lft = 27'(elev_nw) + (27'(elev_w) <<< 1) + 27'(elev_sw);
        rgt = 27'(elev_ne) + (27'(elev_e) <<< 1) + 27'(elev_se);
        bot = 27'(elev_sw) + (27'(elev_s) <<< 1) + 27'(elev_se);
        top = 27'(elev_nw) + (27'(elev_n) <<< 1) + 27'(elev_ne);
        gx1_next = lft - rgt;
        gy1_next = bot - top;
    end

    // ---------------- stage 2: scale by the cell sizes ----------------
    logic               v2_reg;
    logic signed [47:0] x2_reg, y2_reg;
    wsa_pkg::flag_t     f2_reg, f2_next;

    always_comb
    begin
        f2_next     = '0;
        f2_next.nul = nul1_reg;
        f2_next.gxz = (gx1_reg == '0);
        f2_next.gyz = (gy1_reg == '0);
        f2_next.gxn = gx1_reg[26];
    end

    // ---------------- stage 3: fold into the right half plane ----------------
    logic                 v3_reg;
    logic signed [DW-1:0] x3_reg, y3_reg, x3_next, y3_next;
    wsa_pkg::flag_t       f3_reg, f3_next;

    always_comb
    begin
        f3_next     = f2_reg;
        f3_next.off = x2_reg[47];
        if (x2_reg[47]) begin
            x3_next = -DW'(x2_reg);
            y3_next = -DW'(y2_reg);
        end
        else begin
            x3_next = DW'(x2_reg);
            y3_next = DW'(y2_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            gx1_reg  <= gx1_next;
            gy1_reg  <= gy1_next;
            nul1_reg <= (null_mask != '0) || at_border;
            x2_reg   <= 48'(gy1_reg) * 48'($signed({1'b0, h_eff}));
            y2_reg   <= 48'(gx1_reg) * 48'($signed({1'b0, v_eff}));
            f2_reg   <= f2_next;
            x3_reg   <= x3_next;
            y3_reg   <= y3_next;
            f3_reg   <= f3_next;
        end
    end

    // ---------------- first normalize and vectoring pass: aspect ----------------
    logic                 vn1;
    logic signed [DW-1:0] xn1, yn1;
    logic [5:0]           sn1;
    logic [4:0]           fn1_bits;
    wsa_pkg::pre_t        pre_in;

    wsa_norm #(
        .SIDE_W ($bits(wsa_pkg::flag_t))
    ) u_norm_asp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v3_reg),
        .in_x      (x3_reg),
        .in_y      (y3_reg),
        .in_side   (f3_reg),
        .out_valid (vn1),
        .out_x     (xn1),
        .out_y     (yn1),
        .out_s     (sn1),
        .out_side  (fn1_bits)
    );

    assign pre_in.f  = wsa_pkg::flag_t'(fn1_bits);
    assign pre_in.s1 = sn1;

    logic                 vc1;
    logic signed [DW-1:0] xc1, zc1;
    logic [$bits(wsa_pkg::pre_t)-1:0] pc1_bits;
    wsa_pkg::pre_t        pc1;

    wsa_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W ($bits(wsa_pkg::pre_t))
    ) u_cordic_asp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vn1),
        .in_x      (xn1),
        .in_y      (yn1),
        .in_side   (pre_in),
        .out_valid (vc1),
        .out_x     (xc1),
        .out_z     (zc1),
        .out_side  (pc1_bits)
    );

    assign pc1 = wsa_pkg::pre_t'(pc1_bits);

    // ---------------- stage 4: offset aspect, line up magnitude and gain ----------------
    logic                 v4_reg;
    logic signed [DW-1:0] asp4_reg, a4_reg, b4_reg, asp4_next, a4_next, b4_next;
    logic                 nul4_reg, gyz4_reg, gxn4_reg;

    always_comb
    begin
        logic signed [DW-1:0] xa;
        asp4_next = zc1 + (pc1.f.off ? wsa_pkg::PI_Q60 : '0);
        xa = (pc1.f.gxz && pc1.f.gyz) ? '0 : xc1;
        if (pc1.s1 >= 6'd16) begin
            a4_next = xa >>> (pc1.s1 - 6'd16);
            b4_next = DW'(b_reg);
        end
        else begin
            a4_next = xa;
            b4_next = DW'(b_reg) >>> (6'd16 - pc1.s1);
        end
    end

    // ---------------- stage 5: wrap aspect into 0..2pi ----------------
    logic                 v5_reg;
    logic signed [DW-1:0] asp5_reg, a5_reg, b5_reg, asp5_next;
    logic                 nul5_reg, apos5_reg;

    always_comb
    begin
        logic signed [DW-1:0] w;
        if (gyz4_reg) begin
            w = gxn4_reg ? (wsa_pkg::PI_Q60 + wsa_pkg::PI2) : wsa_pkg::PI2;
        end
        else if (asp4_reg < 0) begin
            w = asp4_reg + wsa_pkg::M2PI;
        end
        else begin
            w = asp4_reg;
        end
        asp5_next = (w < 0) ? '0 : w;
    end

    // ---------------- stage 6: round aspect to Q3.13 ----------------
    logic                 v6_reg;
    logic signed [DW-1:0] a6_reg, b6_reg;
    wsa_pkg::post_t       post6_reg, post6_next;

    always_comb
    begin
        logic [DW-1:0] r;
        logic [16:0]   q;
        r = DW'(asp5_reg) + (64'd1 << 46);
        q = r[63:47];
        post6_next.nul   = nul5_reg;
        post6_next.a_pos = apos5_reg;
        post6_next.aq    = (q > wsa_pkg::ASPECT_MAX) ? wsa_pkg::ASPECT_MAX[15:0] : q[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else if (adv) begin
            v4_reg <= vc1;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            asp4_reg  <= asp4_next;
            a4_reg    <= a4_next;
            b4_reg    <= b4_next;
            nul4_reg  <= pc1.f.nul;
            gyz4_reg  <= pc1.f.gyz;
            gxn4_reg  <= pc1.f.gxn;
            asp5_reg  <= asp5_next;
            a5_reg    <= a4_reg;
            b5_reg    <= b4_reg;
            nul5_reg  <= nul4_reg;
            apos5_reg <= (a4_reg > 0);
            a6_reg    <= a5_reg;
            b6_reg    <= b5_reg;
            post6_reg <= post6_next;
        end
    end

    // ---------------- second normalize and vectoring pass: slope ----------------
    logic                 vn2;
    logic signed [DW-1:0] xn2, yn2;
    logic [$bits(wsa_pkg::post_t)-1:0] pn2_bits;

    wsa_norm #(
        .SIDE_W ($bits(wsa_pkg::post_t))
    ) u_norm_slp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (v6_reg),
        .in_x      (b6_reg),
        .in_y      (a6_reg),
        .in_side   (post6_reg),
        .out_valid (vn2),
        .out_x     (xn2),
        .out_y     (yn2),
        .out_s     (),
        .out_side  (pn2_bits)
    );

    logic                 vc2;
    logic signed [DW-1:0] zc2;
    logic [$bits(wsa_pkg::post_t)-1:0] pc2_bits;
    wsa_pkg::post_t       pc2;

    wsa_cordic #(
        .STAGES (CORDIC_STAGES),
        .SIDE_W ($bits(wsa_pkg::post_t))
    ) u_cordic_slp (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vn2),
        .in_x      (xn2),
        .in_y      (yn2),
        .in_side   (pn2_bits),
        .out_valid (vc2),
        .out_x     (),
        .out_z     (zc2),
        .out_side  (pc2_bits)
    );

    assign pc2 = wsa_pkg::post_t'(pc2_bits);

    // ---------------- stage 7: round slope, apply null ----------------
    logic [14:0] slope_next;

    always_comb
    begin
        logic [DW-1:0] zc, r;
        // zero magnitude or a small negative overshoot gives a flat slope
        zc = (!pc2.a_pos || zc2 < 0) ? '0 : DW'(zc2);
        r  = zc + (64'd1 << 45);
        slope_next = r[60:46];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            p_v_reg  <= 1'b0;
            sk_v_reg <= 1'b0;
        end
        else begin
            if (adv) begin
                p_v_reg  <= vc2;
                // capture a stalled result before the pipeline moves on
                sk_v_reg <= p_v_reg && out_stall;
            end
            else if (!out_stall) begin
                sk_v_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv) begin
            p_slope_reg  <= pc2.nul ? '0 : slope_next;
            p_asp_reg    <= pc2.nul ? '0 : pc2.aq;
            p_nul_reg    <= pc2.nul;
            sk_slope_reg <= p_slope_reg;
            sk_asp_reg   <= p_asp_reg;
            sk_nul_reg   <= p_nul_reg;
        end
    end

    // skid register holds the older result and goes first
    assign out_valid    = sk_v_reg || p_v_reg;
    assign slope_angle  = sk_v_reg ? sk_slope_reg : p_slope_reg;
    assign aspect_angle = sk_v_reg ? sk_asp_reg : p_asp_reg;
    assign is_null      = sk_v_reg ? sk_nul_reg : p_nul_reg;

    // centre sample enters only through the null mask
    logic unused_ok;
    assign unused_ok = ^{elev_c, paddr[1:0], pwdata[31:20]};

endmodule

`default_nettype wire
